// ----- hdl/skst_pkg.sv -----
package skst_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;

    localparam int ACTION_W = 2;
    localparam int KEY_IN_W = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_IN_W-1:0] key;
        logic [POS_W-1:0]    position;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

endpackage

// ----- hdl/skst_cmp.sv -----
module skst_cmp #(
    parameter int KEY_WIDTH = skst_pkg::KEY_WIDTH
) (
    input  logic                 i_signed_order,
    input  logic [KEY_WIDTH-1:0] i_a,
    input  logic [KEY_WIDTH-1:0] i_b,
    output logic                 o_lt,
    output logic                 o_eq
);

    logic [KEY_WIDTH-1:0] sign_flip;
    logic [KEY_WIDTH-1:0] a_ord;
    logic [KEY_WIDTH-1:0] b_ord;

    always_comb begin
        sign_flip = '0;
        sign_flip[KEY_WIDTH-1] = i_signed_order;
        a_ord = i_a ^ sign_flip;
        b_ord = i_b ^ sign_flip;
        o_lt  = a_ord < b_ord;
        o_eq  = i_a == i_b;
    end

endmodule

// ----- hdl/skst_ctrl.sv -----
module skst_ctrl #(
    parameter int CAPACITY  = skst_pkg::CAPACITY,
    parameter int KEY_WIDTH = skst_pkg::KEY_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  skst_pkg::t_req    i_req,
    input  logic              i_signed_order,
    input  logic              i_free,
    output logic              o_idle,
    output logic              o_done,
    output skst_pkg::t_result o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > skst_pkg::POS_W) ? CW : skst_pkg::POS_W;
    localparam int KW = KEY_WIDTH;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_HCHK = 4'd3;
    localparam logic [3:0] S_SUR  = 4'd4;
    localparam logic [3:0] S_SUW  = 4'd5;
    localparam logic [3:0] S_INS  = 4'd6;
    localparam logic [3:0] S_SDR  = 4'd7;
    localparam logic [3:0] S_SDW  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]                    r_state;
    logic [skst_pkg::ACTION_W-1:0] r_act;
    logic [KW-1:0]                 r_key;
    logic [CW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hi;
    logic [CW-1:0]                 r_mid;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_ptr;
    logic                          r_hv;
    logic [skst_pkg::STATUS_W-1:0] r_status;
    logic [CW-1:0]                 r_index;
    logic [KW-1:0]                 r_rdata;
    logic [KW-1:0]                 mem [CAPACITY];

    logic [KW+skst_pkg::KEY_IN_W-1:0] key_w;
    logic [KW-1:0]                    key_in;
    logic [EW+skst_pkg::POS_W-1:0]    pos_w;
    logic [EW+CW-1:0]                 cnt_w;
    logic                             pos_lt_cnt;
    logic [CW-1:0]                    pos_p1;
    logic [CW-1:0]                    ptr_p1;
    logic [CW-1:0]                    mid;
    logic                             srch;
    logic                             lt;
    logic                             eq;
    logic                             hit;
    logic [CW-1:0]                    raddr_full;
    logic [AW-1:0]                    raddr;
    logic                             we;
    logic [CW-1:0]                    waddr_full;
    logic [AW-1:0]                    waddr;
    logic [KW-1:0]                    wdata;
    logic [CW+skst_pkg::INDEX_W-1:0]  index_w;
    logic [CW+skst_pkg::COUNT_W-1:0]  count_w;

    skst_cmp #(
        .KEY_WIDTH(KW)
    ) u_cmp (
        .i_signed_order(i_signed_order),
        .i_a           (r_rdata),
        .i_b           (r_key),
        .o_lt          (lt),
        .o_eq          (eq)
    );

    always_comb begin
        key_w      = {{KW{1'b0}}, i_req.key};
        key_in     = key_w[KW-1:0];
        pos_w      = {{EW{1'b0}}, i_req.position};
        cnt_w      = {{EW{1'b0}}, r_cnt};
        pos_lt_cnt = pos_w[EW-1:0] < cnt_w[EW-1:0];
        pos_p1     = pos_w[CW-1:0] + ONE_C;
        ptr_p1     = r_ptr + ONE_C;
        mid        = r_lo + ((r_hi - r_lo) >> 1);
        srch       = r_lo < r_hi;
        hit        = r_hv && eq;

        case (r_state)
            S_SRD:   raddr_full = srch ? mid : r_lo;
            S_SUR:   raddr_full = r_ptr;
            S_SDR:   raddr_full = ptr_p1;
            default: raddr_full = r_lo;
        endcase
        raddr = raddr_full[AW-1:0];

        case (r_state)
            S_SUW: begin
                we         = 1'b1;
                waddr_full = ptr_p1;
                wdata      = r_rdata;
            end
            S_INS: begin
                we         = 1'b1;
                waddr_full = r_lo;
                wdata      = r_key;
            end
            S_SDW: begin
                we         = 1'b1;
                waddr_full = r_ptr;
                wdata      = r_rdata;
            end
            default: begin
                we         = 1'b0;
                waddr_full = r_ptr;
                wdata      = r_rdata;
            end
        endcase
        waddr = waddr_full[AW-1:0];

        index_w = {{skst_pkg::INDEX_W{1'b0}}, r_index};
        count_w = {{skst_pkg::COUNT_W{1'b0}}, r_cnt};
        o_res.status      = r_status;
        o_res.found_index = index_w[skst_pkg::INDEX_W-1:0];
        o_res.entry_count = count_w[skst_pkg::COUNT_W-1:0];
        o_idle = r_state == S_IDLE;
        o_done = (r_state == S_DONE) && i_free;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_act    <= i_req.action;
                        r_key    <= key_in;
                        r_lo     <= '0;
                        r_hi     <= r_cnt;
                        r_index  <= '0;
                        case (i_req.action)
                            skst_pkg::ACT_ADD, skst_pkg::ACT_FIND: begin
                                r_status <= skst_pkg::ST_OK;
                                r_state  <= S_SRD;
                            end
                            skst_pkg::ACT_ERASE: begin
                                if (!pos_lt_cnt) begin
                                    r_status <= skst_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= skst_pkg::ST_OK;
                                    r_ptr    <= pos_w[CW-1:0];
                                    r_cnt    <= r_cnt - ONE_C;
                                    r_state  <= (pos_p1 < r_cnt) ? S_SDR : S_DONE;
                                end
                            end
                            default: begin
                                r_status <= skst_pkg::ST_OK;
                                r_cnt    <= '0;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SRD: begin
                    if (srch) begin
                        r_mid   <= mid;
                        r_state <= S_SCMP;
                    end else begin
                        r_hv    <= r_lo < r_cnt;
                        r_state <= S_HCHK;
                    end
                end
                S_SCMP: begin
                    if (lt) begin
                        r_lo <= r_mid + ONE_C;
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SRD;
                end
                S_HCHK: begin
                    if (r_act == skst_pkg::ACT_FIND) begin
                        if (hit) begin
                            r_index <= r_lo;
                        end else begin
                            r_status <= skst_pkg::ST_NOTFOUND;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_index <= r_lo;
                        if (hit) begin
                            r_status <= skst_pkg::ST_DUP;
                            r_state  <= S_DONE;
                        end else if (r_cnt >= CAP_C) begin
                            r_status <= skst_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else if (r_lo < r_cnt) begin
                            r_ptr   <= r_cnt - ONE_C;
                            r_state <= S_SUR;
                        end else begin
                            r_state <= S_INS;
                        end
                    end
                end
                S_SUR: begin
                    r_state <= S_SUW;
                end
                S_SUW: begin
                    if (r_ptr == r_lo) begin
                        r_state <= S_INS;
                    end else begin
                        r_ptr   <= r_ptr - ONE_C;
                        r_state <= S_SUR;
                    end
                end
                S_INS: begin
                    r_cnt   <= r_cnt + ONE_C;
                    r_state <= S_DONE;
                end
                S_SDR: begin
                    r_state <= S_SDW;
                end
                S_SDW: begin
                    r_ptr   <= ptr_p1;
                    r_state <= ((ptr_p1 + ONE_C) < r_hi) ? S_SDR : S_DONE;
                end
                S_DONE: begin
                    if (i_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/sorted_key_set_table_core.sv -----
// Sorted key set table: holds up to CAPACITY unique keys in ascending order.
// Request channel (i_valid/o_ready): action, key, position. Actions are add,
// find, erase at index and clear. Result channel (o_valid/i_ready): status,
// found_index and entry_count, one result beat per request beat.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): i_cfg_data selects
// unsigned (0) or two's complement (1) key order; write it only when idle.
// Add and find run a binary search over the n held keys, one step at a time
// through the one compare unit and the key memory (one read port, one write
// port); an add that inserts then moves each entry above the slot up by one
// and writes the new key. Erase moves each entry above the position down by
// one; clear only empties the count.
// One request is in flight at a time: o_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next request is taken while the receiver stalls; a later result then holds
// in the sequencer until the output register frees up.
// Reset (synchronous, active low) empties the set, clears the output valid
// and selects unsigned order; key memory contents are not cleared.
module sorted_key_set_table_core #(
    parameter int CAPACITY  = skst_pkg::CAPACITY,
    parameter int KEY_WIDTH = skst_pkg::KEY_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [skst_pkg::ACTION_W-1:0]   i_action,
    input  logic [skst_pkg::KEY_IN_W-1:0]   i_key,
    input  logic [skst_pkg::POS_W-1:0]      i_position,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [skst_pkg::STATUS_W-1:0]   o_status,
    output logic [skst_pkg::INDEX_W-1:0]    o_found_index,
    output logic [skst_pkg::COUNT_W-1:0]    o_entry_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);

    logic              r_signed_order;
    logic              r_out_valid;
    skst_pkg::t_result r_out;

    skst_pkg::t_req    req;
    skst_pkg::t_result res;
    logic              idle;
    logic              done;
    logic              free;
    logic              start;

    always_comb begin
        req.action   = i_action;
        req.key      = i_key;
        req.position = i_position;
        free         = !r_out_valid || i_ready;
        o_ready      = idle;
        start        = i_valid && idle;
        o_cfg_ready  = 1'b1;
    end

    skst_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_WIDTH(KEY_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_req         (req),
        .i_signed_order(r_signed_order),
        .i_free        (free),
        .o_idle        (idle),
        .o_done        (done),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_order <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_signed_order <= i_cfg_data;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_index = r_out.found_index;
    assign o_entry_count = r_out.entry_count;

endmodule
